### rtl/bmm_pkg.sv
// Package for the bipartite matching block: widths, phase codes and the
// interface-independent constants. Depends on nothing.
`default_nettype none
package bmm_pkg;
    localparam int MAX_LEFT_DEF  = 32;
    localparam int MAX_RIGHT_DEF = 32;
    localparam int CNT_W = 6;
    localparam int IDX_W = 5;
    localparam int ROW_W = 32;

    localparam logic [0:0] CFG_LEFT  = 1'b0;
    localparam logic [0:0] CFG_RIGHT = 1'b1;

    typedef enum logic [3:0] {
        PH_LOAD,
        PH_CLEAR,
        PH_SEED,
        PH_POP,
        PH_LROW,
        PH_LSCAN,
        PH_RCHK,
        PH_FLIP_RD,
        PH_FLIP_WR,
        PH_OUT_RD,
        PH_OUT
    } phase_t;
endpackage
`default_nettype wire

### rtl/bmm_if.sv
// Channel interfaces for the matching block: input rows, results and the
// configuration writes. Depends on nothing.
`default_nettype none
interface bmm_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic        final_row;
    modport source (output valid, row_index, row_bits, final_row, input ready);
    modport sink (input valid, row_index, row_bits, final_row, output ready);
endinterface

interface bmm_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] left_vertex;
    logic       is_matched;
    logic [4:0] partner;
    logic       end_of_run;
    modport source (output valid, left_vertex, is_matched, partner, end_of_run,
                    input ready);
    modport sink (input valid, left_vertex, is_matched, partner, end_of_run,
                  output ready);
endinterface

interface bmm_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [5:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/bipartite_max_matching.sv
// Top level of the maximum bipartite matching block (BFS augmenting paths).
// Uses bmm_pkg and the channel interfaces of bmm_if.sv.
//
// Usage: rows arrive on the input channel, one transfer per cycle, each
// written into the adjacency memory. A transfer with final_row set stores
// its row and starts a run; the input channel is then held not ready until
// every result has been delivered. A run clears the matching (one entry per
// vertex of the larger side in use), then repeats searches. Each search
// seeds the queue by checking every left vertex in use (one per cycle) and
// pops one entry per step. A left entry costs the pop, one row read and a
// scan of one right vertex per cycle; a right entry costs the pop and a
// check of its partner. A found path is flipped edge by edge, a read step
// and then a write step per edge. Results then leave one per left vertex,
// each read from the partner memory and then loaded into a held output
// register: a stalled receiver simply freezes the run's output. Reset
// returns to the loading phase with both counts at 32; row contents after
// reset are undefined until written. Configuration writes are always
// accepted and must come while idle.
`default_nettype none
module bipartite_max_matching
    import bmm_pkg::*;
#(
    parameter int MAX_LEFT  = MAX_LEFT_DEF,
    parameter int MAX_RIGHT = MAX_RIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bmm_in_if.sink    in_ch,
    bmm_out_if.source out_ch,
    bmm_cfg_if.sink   cfg
);
    localparam int LW = (MAX_LEFT  > 1) ? $clog2(MAX_LEFT)  : 1;
    localparam int RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
    localparam int LLIM = (MAX_LEFT  < 32) ? MAX_LEFT  : 32;
    localparam int RLIM = (MAX_RIGHT < 32) ? MAX_RIGHT : 32;
    localparam int QD = LLIM + RLIM;
    localparam int QW = $clog2(QD + 1);
    localparam int QA = $clog2(QD);
    localparam int VW = (LW > RW ? LW : RW) + 1;   // tag bit + index

    // Memories: adjacency rows, partners (valid+index), parents, queue.
    logic [ROW_W-1:0] adj_mem [MAX_LEFT];
    logic [RW:0]      lp_mem  [MAX_LEFT];
    logic [LW:0]      rp_mem  [MAX_RIGHT];
    logic [LW-1:0]    par_mem [MAX_RIGHT];
    logic [VW-1:0]    q_mem   [QD];

    // Visited marks are flip-flops, cleared at the start of each search.
    logic [MAX_LEFT-1:0]  vl_reg, vl_next;
    logic [MAX_RIGHT-1:0] vr_reg, vr_next;

    phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] lcnt_reg, rcnt_reg;
    logic [CNT_W-1:0] nl, nr;
    logic [CNT_W-1:0] i_reg, i_next;     // general counter
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic found_reg, found_next;
    logic [VW-1:0] v_reg, v_next;        // popped entry
    logic [RW:0]   vpart_reg, vpart_next; // partner of popped left vertex
    logic [RW-1:0] j_reg, j_next;        // right vertex of flip

    // Synchronous read ports.
    logic [ROW_W-1:0] adj_q;
    logic [RW:0]      lp_q;
    logic [LW:0]      rp_q;
    logic [LW-1:0]    par_q;
    logic [VW-1:0]    q_q;
    logic [LW-1:0]    adj_ra, lp_ra;
    logic [RW-1:0]    rp_ra, par_ra;
    logic [QW-1:0]    q_ra;

    // Write controls.
    logic lp_we, rp_we, par_we, q_we;
    logic [LW-1:0] lp_wa;
    logic [RW:0]   lp_wd;
    logic [RW-1:0] rp_wa, par_wa;
    logic [LW:0]   rp_wd;
    logic [LW-1:0] par_wd;
    logic [VW-1:0] q_wd;
    logic [QW-1:0] q_wa_w;
    logic [ROW_W-1:0] row_reg, row_next;

    logic out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] ov_reg, ov_next, op_reg, op_next;
    logic om_reg, om_next, oe_reg, oe_next;

    logic in_fire;
    logic in_ready_w;
    assign in_ready_w = (phase_reg == PH_LOAD);
    assign in_ch.ready = in_ready_w;
    assign in_fire = in_ch.valid && in_ready_w;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        nl = lcnt_reg;
        if (nl == '0) nl = CNT_W'(1);
        else if (nl > CNT_W'(LLIM)) nl = CNT_W'(LLIM);
        nr = rcnt_reg;
        if (nr == '0) nr = CNT_W'(1);
        else if (nr > CNT_W'(RLIM)) nr = CNT_W'(RLIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= CNT_W'(32);
            rcnt_reg <= CNT_W'(32);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LEFT:  lcnt_reg <= cfg.data;
                CFG_RIGHT: rcnt_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Memory blocks. The left-partner and queue memories forward a write to the
    // entry being read in the same cycle, so a search may start or pop right
    // behind an update of that entry.
    assign q_wa_w = tail_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && (32'(in_ch.row_index) < MAX_LEFT))
            adj_mem[LW'(in_ch.row_index)] <= in_ch.row_bits;
        adj_q <= adj_mem[adj_ra];
    end
    always_ff @(posedge clk)
    begin
        if (lp_we) lp_mem[lp_wa] <= lp_wd;
        if (lp_we && lp_wa == lp_ra) lp_q <= lp_wd;
        else lp_q <= lp_mem[lp_ra];
    end
    always_ff @(posedge clk)
    begin
        if (rp_we) rp_mem[rp_wa] <= rp_wd;
        rp_q <= rp_mem[rp_ra];
    end
    always_ff @(posedge clk)
    begin
        if (par_we) par_mem[par_wa] <= par_wd;
        par_q <= par_mem[par_ra];
    end
    always_ff @(posedge clk)
    begin
        if (q_we) q_mem[QA'(q_wa_w)] <= q_wd;
        if (q_we && q_wa_w == q_ra) q_q <= q_wd;
        else q_q <= q_mem[QA'(q_ra)];
    end

    // Current scan position and its edge test (LSCAN).
    logic [RW-1:0] sj;
    logic edge_ok;
    assign sj = RW'(i_reg);
    always_comb
    begin
        edge_ok = row_reg[i_reg[4:0]] && !vr_reg[sj]
            && !(vpart_reg[RW] && vpart_reg[RW-1:0] == sj);
    end

    // Next-state logic.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_LOAD:   if (in_fire && in_ch.final_row) phase_next = PH_CLEAR;
            PH_CLEAR:  if (i_reg + 1'b1 >= ((nl > nr) ? nl : nr)) phase_next = PH_SEED;
            PH_SEED:   if (i_reg + 1'b1 >= nl) phase_next = PH_POP;
            PH_POP:
            begin
                if (found_reg) phase_next = PH_FLIP_RD;
                else if (head_reg == tail_reg) phase_next = PH_OUT_RD;
                else if (!q_q[VW-1]) phase_next = PH_LROW;
                else phase_next = PH_RCHK;
            end
            PH_LROW:   phase_next = PH_LSCAN;
            PH_LSCAN:  if (i_reg + 1'b1 >= nr) phase_next = PH_POP;
            PH_RCHK:   phase_next = PH_POP;
            PH_FLIP_RD: phase_next = PH_FLIP_WR;
            PH_FLIP_WR: phase_next = lp_q[RW] ? PH_FLIP_RD : PH_SEED;
            PH_OUT_RD: phase_next = PH_OUT;
            PH_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                    phase_next = (i_reg >= nl) ? PH_LOAD : PH_OUT_RD;
            end
            default:   phase_next = PH_LOAD;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        i_next = i_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        found_next = found_reg;
        v_next = v_reg;
        vpart_next = vpart_reg;
        j_next = j_reg;
        row_next = row_reg;
        vl_next = vl_reg;
        vr_next = vr_reg;
        out_valid_next = out_valid_reg;
        ov_next = ov_reg; op_next = op_reg; om_next = om_reg; oe_next = oe_reg;
        lp_we = 1'b0; lp_wa = '0; lp_wd = '0;
        rp_we = 1'b0; rp_wa = '0; rp_wd = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0;
        q_we = 1'b0; q_wd = '0;
        adj_ra = LW'(v_reg);
        lp_ra = LW'(v_reg);
        rp_ra = RW'(v_reg);
        par_ra = j_reg;
        q_ra = head_reg;
        if (out_valid_reg && out_ch.ready) out_valid_next = 1'b0;
        unique case (phase_reg)
            PH_LOAD:
            begin
                i_next = '0;
            end
            PH_CLEAR:
            begin
                // Matching cleared; each memory port takes one entry a cycle.
                if (32'(i_reg) < MAX_LEFT)
                begin
                    lp_we = 1'b1; lp_wa = LW'(i_reg); lp_wd = '0;
                end
                if (32'(i_reg) < MAX_RIGHT)
                begin
                    rp_we = 1'b1; rp_wa = RW'(i_reg); rp_wd = '0;
                end
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 >= ((nl > nr) ? nl : nr))
                begin
                    i_next = '0;
                    vl_next = '0; vr_next = '0;
                    head_next = '0; tail_next = '0; found_next = 1'b0;
                end
                lp_ra = '0;
            end
            PH_SEED:
            begin
                // Partner of vertex i is read the cycle before; use lp_q of
                // i_reg, which was addressed last cycle.
                lp_ra = LW'(i_reg + 1'b1);
                if (!lp_q[RW])
                begin
                    vl_next[LW'(i_reg)] = 1'b1;
                    q_we = 1'b1;
                    q_wd = VW'(i_reg);
                    tail_next = tail_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 >= nl) i_next = '0;
            end
            PH_POP:
            begin
                if (!found_reg && head_reg != tail_reg)
                begin
                    v_next = q_q;
                    head_next = head_reg + 1'b1;
                    adj_ra = LW'(q_q);
                    lp_ra = LW'(q_q);
                    rp_ra = RW'(q_q);
                    i_next = '0;
                end
                else if (!found_reg)
                begin
                    // No path left: results start from left vertex 0.
                    i_next = '0;
                end
                q_ra = head_reg + 1'b1;
                par_ra = j_reg;
            end
            PH_LROW:
            begin
                row_next = adj_q;
                vpart_next = lp_q;
            end
            PH_LSCAN:
            begin
                if (edge_ok)
                begin
                    vr_next[sj] = 1'b1;
                    par_we = 1'b1; par_wa = sj; par_wd = LW'(v_reg);
                    q_we = 1'b1;
                    q_wd = {1'b1, (VW-1)'(sj)};
                    tail_next = tail_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                q_ra = head_reg;
            end
            PH_RCHK:
            begin
                if (rp_q[LW])
                begin
                    if (!vl_reg[rp_q[LW-1:0]])
                    begin
                        vl_next[rp_q[LW-1:0]] = 1'b1;
                        q_we = 1'b1;
                        q_wd = VW'(rp_q[LW-1:0]);
                        tail_next = tail_reg + 1'b1;
                    end
                end
                else
                begin
                    found_next = 1'b1;
                    j_next = RW'(v_reg);
                end
                q_ra = head_reg;
                par_ra = RW'(v_reg);
            end
            PH_FLIP_RD:
            begin
                // par_q holds parent of j (address j_reg held since RCHK).
                lp_ra = par_q;
                v_next = VW'(par_q);
            end
            PH_FLIP_WR:
            begin
                lp_we = 1'b1; lp_wa = LW'(v_reg); lp_wd = {1'b1, j_reg};
                rp_we = 1'b1; rp_wa = j_reg; rp_wd = {1'b1, LW'(v_reg)};
                j_next = lp_q[RW-1:0];
                par_ra = lp_q[RW-1:0];
                lp_ra = '0;
                if (!lp_q[RW])
                begin
                    i_next = '0;
                    vl_next = '0; vr_next = '0;
                    head_next = '0; tail_next = '0; found_next = 1'b0;
                end
            end
            PH_OUT_RD:
            begin
                lp_ra = LW'(i_reg);
            end
            PH_OUT:
            begin
                lp_ra = LW'(i_reg);
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    ov_next = i_reg[IDX_W-1:0];
                    om_next = lp_q[RW];
                    op_next = lp_q[RW] ? IDX_W'(lp_q[RW-1:0]) : '0;
                    oe_next = (i_reg + 1'b1 == nl);
                    i_next = i_reg + 1'b1;
                end
                if (!out_valid_reg || out_ch.ready)
                    if (i_reg + 1'b1 >= nl) i_next = CNT_W'(63);
                if (i_reg >= nl)
                begin
                    out_valid_next = out_valid_reg && !out_ch.ready;
                    i_next = i_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOAD;
            i_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            found_reg <= 1'b0;
            vl_reg <= '0;
            vr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            i_reg <= i_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            found_reg <= found_next;
            vl_reg <= vl_next;
            vr_reg <= vr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        vpart_reg <= vpart_next;
        j_reg <= j_next;
        row_reg <= row_next;
        ov_reg <= ov_next;
        op_reg <= op_next;
        om_reg <= om_next;
        oe_reg <= oe_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.left_vertex = ov_reg;
    assign out_ch.is_matched = om_reg;
    assign out_ch.partner = op_reg;
    assign out_ch.end_of_run = oe_reg;
endmodule
`default_nettype wire

### rtl/bmm_checker.sv
// Port-level checker for the matching block, bound to its top level.
// Does not use bmm_pkg; it sees only the top level's ports.
`default_nettype none
module bmm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_final,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_matched,
    input wire logic [4:0] out_partner,
    input wire logic [4:0] out_vertex
);
    // A final row closes the input until results are out.
    a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> !in_ready)
        else $error("input open after final row");
    // Results only appear while loading is closed.
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result offered while rows are accepted");
    // Unmatched results carry partner zero.
    a_partner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_matched |-> out_partner == 5'd0)
        else $error("unmatched result with partner");
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_vertex))
        else $error("result changed under stall");
endmodule

bind bipartite_max_matching bmm_checker u_bmm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_final(in_ch.final_row),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_matched(out_ch.is_matched),
    .out_partner(out_ch.partner),
    .out_vertex(out_ch.left_vertex)
);
`default_nettype wire
